// ===== hdl/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types and constants of the SHA-256 message hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned DIGEST_N = 8;
   localparam int unsigned WINDOW_N = 16;
   localparam int unsigned ROUND_N  = 64;

   typedef logic [WORD_W-1:0] word_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PAD,
      ST_ROUND,
      ST_FINAL,
      ST_OUT
   } state_type;

   // Progress of the padding that follows the final message word.
   typedef enum logic [2:0] {
      PAD_NONE,
      PAD_MARK,
      PAD_ZERO,
      PAD_LEN,
      PAD_DONE
   } pad_type;

   localparam word_type PAD_MARK_WORD = 32'h8000_0000;

   localparam word_type SHA_IV [DIGEST_N] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type ROUND_K [ROUND_N] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

// ===== hdl/sha256_req_if.sv =====
// ----------------------------------------------------------------------------
// SHA-256 request channel
// Valid/ready channel that carries message words into the hasher.
// ----------------------------------------------------------------------------
interface sha256_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] data_word;
   logic [2:0]  byte_count;
   logic        last_word;

   modport source (output valid, data_word, byte_count, last_word, input ready);
   modport sink   (input valid, data_word, byte_count, last_word, output ready);
endinterface

// ===== hdl/sha256_rsp_if.sv =====
// ----------------------------------------------------------------------------
// SHA-256 response channel
// Valid/ready channel that carries digest words out of the hasher.
// ----------------------------------------------------------------------------
interface sha256_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        digest_last;

   modport source (output valid, digest_word, word_index, digest_last, input ready);
   modport sink   (input valid, digest_word, word_index, digest_last, output ready);
endinterface

// ===== hdl/sha256_message_hasher.sv =====
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Hashes a stream of big-endian 32-bit message words and returns the digest.
// ----------------------------------------------------------------------------
// A message arrives as 32-bit words, first byte in the top bits, one word per
// request transaction; only the word flagged last_word may carry fewer than
// four bytes, as given by byte_count (values above four count as four), and an
// empty message is a single last word with a byte count of zero. Words are
// taken at one per cycle until sixteen fill the schedule window; the block
// then drops ready and runs the 64 compression rounds on one shared round
// datapath, one round per cycle, followed by a step that folds the working
// variables into the chaining value. The single round unit thus bounds the
// throughput. After the last word the sequencer places the 0x80 marker right
// behind the valid bytes, inside the last word when it has fewer than four
// bytes, then inserts the zero fill and the 64-bit bit length itself, one word
// per cycle between compressions; a second block is compressed when the tail
// leaves no room for the length. The eight digest words then leave as
// eight response transactions, h0 first, with digest_last on the eighth; no
// request is taken until the eighth is accepted, after which the chaining
// value returns to the SHA-256 initial values for the next message.
// ----------------------------------------------------------------------------
module sha256_message_hasher
   import sha256_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   sha256_req_if.sink        req_chan,
   sha256_rsp_if.source      rsp_chan
);

   function automatic word_type rotr(input word_type v, input int unsigned s);
      return (v >> s) | (v << (WORD_W - s));
   endfunction

   function automatic word_type big_sigma0(input word_type v);
      return rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type v);
      return rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
   endfunction

   function automatic word_type small_sigma0(input word_type v);
      return rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type v);
      return rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
   endfunction

   // Sequencer and counters.
   state_type   state_ff, state_in;
   pad_type     phase_ff, phase_in;
   logic [3:0]  slot_ff, slot_in;
   logic [5:0]  round_ff, round_in;
   logic [2:0]  idx_ff, idx_in;
   logic [63:0] bits_ff, bits_in;

   // Chaining value, working variables a..h and the schedule window. The
   // window is a shift line: entry 0 holds the word of the current round.
   word_type    h_ff [DIGEST_N];
   word_type    h_in [DIGEST_N];
   word_type    v_ff [DIGEST_N];
   word_type    v_in [DIGEST_N];
   word_type    w_ff [WINDOW_N];
   word_type    w_in [WINDOW_N];

   logic        ins_en;
   word_type    ins_word;
   logic        pad_go;
   logic [2:0]  byte_sat;
   word_type    tail_word;

   word_type    t1;
   word_type    t2;
   word_type    sched_new;

   // Round datapath, shared by all 64 rounds.
   assign t1 = v_ff[7] + big_sigma1(v_ff[4])
             + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
             + ROUND_K[round_ff] + w_ff[0];
   assign t2 = big_sigma0(v_ff[0])
             + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));

   // Schedule word sixteen rounds ahead of the current one.
   assign sched_new = small_sigma1(w_ff[14]) + w_ff[9] + small_sigma0(w_ff[1]) + w_ff[0];

   // The final word keeps its valid bytes and takes the marker right behind them.
   assign byte_sat = (req_chan.byte_count > 3'd4) ? 3'd4 : req_chan.byte_count;

   always_comb begin
      case (byte_sat)
         3'd0:    tail_word = PAD_MARK_WORD;
         3'd1:    tail_word = {req_chan.data_word[31:24], 24'h80_0000};
         3'd2:    tail_word = {req_chan.data_word[31:16], 16'h8000};
         3'd3:    tail_word = {req_chan.data_word[31:8], 8'h80};
         default: tail_word = req_chan.data_word;
      endcase
   end

   assign req_chan.ready       = (state_ff == ST_LOAD);
   assign rsp_chan.valid       = (state_ff == ST_OUT);
   assign rsp_chan.digest_word = h_ff[idx_ff];
   assign rsp_chan.word_index  = idx_ff;
   assign rsp_chan.digest_last = (idx_ff == 3'd7);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      slot_in  = slot_ff;
      round_in = round_ff;
      idx_in   = idx_ff;
      bits_in  = bits_ff;
      h_in     = h_ff;
      v_in     = v_ff;
      w_in     = w_ff;
      ins_en   = 1'b0;
      ins_word = '0;
      pad_go   = 1'b0;

      case (state_ff)
         ST_LOAD: begin
            if (req_chan.valid) begin
               ins_en = 1'b1;
               if (!req_chan.last_word) begin
                  bits_in  = bits_ff + 64'd32;
                  ins_word = req_chan.data_word;
               end else begin
                  bits_in  = bits_ff + {58'd0, byte_sat, 3'b000};
                  ins_word = tail_word;
                  phase_in = (byte_sat == 3'd4) ? PAD_MARK : PAD_ZERO;
                  pad_go   = 1'b1;
               end
            end
         end
         ST_PAD: begin
            ins_en = 1'b1;
            case (phase_ff)
               PAD_MARK: begin
                  ins_word = PAD_MARK_WORD;
                  phase_in = PAD_ZERO;
               end
               PAD_ZERO: begin
                  // Zeros run up to the two slots that hold the length.
                  if (slot_ff == 4'd14) begin
                     ins_word = bits_ff[63:32];
                     phase_in = PAD_LEN;
                  end else begin
                     ins_word = '0;
                  end
               end
               PAD_LEN: begin
                  ins_word = bits_ff[31:0];
                  phase_in = PAD_DONE;
               end
               default: begin
                  ins_word = '0;
               end
            endcase
         end
         ST_ROUND: begin
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            for (int i = 0; i < WINDOW_N - 1; i++) begin
               w_in[i] = w_ff[i + 1];
            end
            w_in[WINDOW_N - 1] = sched_new;
            round_in = round_ff + 6'd1;
            if (round_ff == 6'(ROUND_N - 1)) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            for (int i = 0; i < DIGEST_N; i++) begin
               h_in[i] = h_ff[i] + v_ff[i];
            end
            case (phase_ff)
               PAD_NONE: state_in = ST_LOAD;
               PAD_DONE: state_in = ST_OUT;
               default:  state_in = ST_PAD;
            endcase
         end
         ST_OUT: begin
            if (rsp_chan.ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  h_in     = SHA_IV;
                  bits_in  = '0;
                  phase_in = PAD_NONE;
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      // A word entering the window; the sixteenth one starts the rounds.
      if (ins_en) begin
         for (int i = 0; i < WINDOW_N - 1; i++) begin
            w_in[i] = w_ff[i + 1];
         end
         w_in[WINDOW_N - 1] = ins_word;
         slot_in = slot_ff + 4'd1;
         if (slot_ff == 4'd15) begin
            state_in = ST_ROUND;
            round_in = '0;
            v_in     = h_ff;
         end else if (pad_go) begin
            state_in = ST_PAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         phase_ff <= PAD_NONE;
         slot_ff  <= '0;
         round_ff <= '0;
         idx_ff   <= '0;
         bits_ff  <= '0;
         h_ff     <= SHA_IV;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         slot_ff  <= slot_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
         bits_ff  <= bits_in;
         h_ff     <= h_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
      w_ff <= w_in;
   end

endmodule

// ===== hdl/sha256_checker.sv =====
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Concurrent assertions on the ports of the SHA-256 message hasher.
// ----------------------------------------------------------------------------
module sha256_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_last_word,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_word_index,
   input logic       rsp_digest_last
);

   // Requests are never taken while a digest is being delivered.
   assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("request ready while digest words are pending");

   // The final message word always starts processing, so ready drops.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last_word) |=> !req_ready)
      else $error("ready stayed high after the final message word");

   // Digest words leave in order without gaps.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_digest_last) |=>
         (rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest words out of order");

   // The flag on the final digest word matches its position.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digest_last == (rsp_word_index == 3'd7)))
      else $error("digest_last does not match word_index");

   // A delivered digest is followed by a return to accepting messages.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_digest_last) |=> (!rsp_valid && req_ready))
      else $error("hasher did not return to accepting words after the digest");

endmodule

bind sha256_message_hasher sha256_checker u_sha256_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_last_word   (req_chan.last_word),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_word_index  (rsp_chan.word_index),
   .rsp_digest_last (rsp_chan.digest_last)
);
